// ===== rtl/msws_pkg.sv =====
`timescale 1ns / 1ps

package msws_pkg;

  // Field widths and generator constants.
  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CntW  = $clog2(DataW);
  localparam logic [DataW-1:0] WeylStep = 64'hb5ad4eceda1ce2a9;
  localparam logic [CntW-1:0]  LastStep = CntW'(DataW - 1);

  typedef logic [DataW-1:0] data_t;

  // Control state of the request sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_DIV,
    ST_WAIT
  } state_e;

  // Status that a serial arithmetic unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== rtl/msws_req_if.sv =====
`timescale 1ns / 1ps

interface msws_req_if import msws_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t bound;

  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

// ===== rtl/msws_rsp_if.sv =====
`timescale 1ns / 1ps

interface msws_rsp_if import msws_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  bound_error;

  modport source (output valid, output value, output bound_error, input ready);
  modport sink   (input valid, input value, input bound_error, output ready);
endinterface

// ===== rtl/msws_bounded_random.sv =====
`timescale 1ns / 1ps
// Bounded pseudo-random numbers from a 64-bit middle-square Weyl generator.
// The request channel carries a bound; each accepted request advances the
// generator once and returns one response with value = state mod bound, or
// value 0 with bound_error set when the bound is zero.
// The seed register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce it.
// It is loaded into the mixer on the first request after reset only.
// Each request passes through the bit-serial squarer, the mix step and the
// bit-serial restoring divider, then the output register; a zero bound
// skips the divider. One request is processed at a time: a new request is
// taken only once the previous result has left the sequencer.
// The response sits in an output register: a new request is taken while it
// waits, and a finished result waits in the sequencer until the receiver
// has drained the output register.
// Reset clears the seed, the mixer and Weyl state and the seeded flag, and
// drops any pending response.
module msws_bounded_random import msws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  data_t       cfg_wdata_i,
  msws_req_if.sink    req_i,
  msws_rsp_if.source  rsp_o
);

  state_e       state_q, state_d;
  data_t        seed_q;
  data_t        mixer_q, mixer_d;
  data_t        weyl_q, weyl_d;
  logic         seeded_q, seeded_d;
  data_t        bound_q;
  data_t        res_value_q, res_value_d;
  logic         res_err_q, res_err_d;
  logic         out_valid_q, out_valid_d;
  data_t        out_value_q, out_value_d;
  logic         out_err_q, out_err_d;
  logic         req_fire;
  logic         mul_start;
  logic         div_start;
  data_t        mul_operand;
  data_t        product;
  data_t        mixed;
  data_t        swapped;
  data_t        remainder;
  unit_status_t mul_st;
  unit_status_t div_st;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign mul_operand = seeded_q ? mixer_q : seed_q;
  assign mul_start   = req_fire;
  assign mixed       = product + weyl_q;
  assign swapped     = {mixed[HalfW-1:0], mixed[DataW-1:HalfW]};

  msws_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_operand),
    .product_o (product),
    .status_o  (mul_st)
  );

  msws_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mixer_q),
    .divisor_i   (bound_q),
    .remainder_o (remainder),
    .status_o    (div_st)
  );

  // Sequencer: square, mix, divide unless the bound is zero, then hand the result to the output register.
  always_comb begin
    state_d     = state_q;
    mixer_d     = mixer_q;
    weyl_d      = weyl_q;
    seeded_d    = seeded_q;
    res_value_d = res_value_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          seeded_d = 1'b1;
          weyl_d   = weyl_q + WeylStep;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_st.done) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        mixer_d = swapped;
        if (bound_q == '0) begin
          res_value_d = '0;
          res_err_d   = 1'b1;
          state_d     = ST_WAIT;
        end else begin
          res_err_d = 1'b0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // The divider reads the mixer register, which now holds the new state.
        div_start = !div_st.busy && !div_st.done;
        if (div_st.done) begin
          res_value_d = remainder;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_value_q;
          out_err_d   = res_err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      mixer_q     <= '0;
      weyl_q      <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mixer_q     <= mixer_d;
      weyl_q      <= weyl_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      bound_q <= req_i.bound;
    end
    res_value_q <= res_value_d;
    res_err_q   <= res_err_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.value       = out_value_q;
  assign rsp_o.bound_error = out_err_q;

  // The serial units only finish in the state that waits for them.
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  // After any request transfer the generator counts as seeded.
  a_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> seeded_q)
    else $error("generator not marked seeded after a request");

  // A zero-bound response always carries value zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_value_q == '0)
    else $error("bound error response with nonzero value");

endmodule

// ===== rtl/msws_mul.sv =====
`timescale 1ns / 1ps

module msws_mul import msws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  data_t        operand_i,
  output data_t        product_o,
  output unit_status_t status_o
);

  data_t          a_q, a_d;
  data_t          b_q, b_d;
  data_t          acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;

  // Shift-add squaring, one multiplier bit per cycle, kept modulo 2^64.
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = operand_i;
      b_d    = operand_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + (b_q[0] ? a_q : '0);
      a_d   = {a_q[DataW-2:0], 1'b0};
      b_d   = {1'b0, b_q[DataW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign product_o     = acc_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== rtl/msws_div.sv =====
`timescale 1ns / 1ps

module msws_div import msws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  data_t        dividend_i,
  input  data_t        divisor_i,
  output data_t        remainder_o,
  output unit_status_t status_o
);

  data_t           n_q, n_d;
  data_t           d_q, d_d;
  data_t           rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DataW:0]  shifted;
  logic [DataW:0]  trial;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  assign shifted = {rem_q, n_q[DataW-1]};
  assign trial   = shifted - {1'b0, d_q};

  always_comb begin
    n_d    = n_q;
    d_d    = d_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = dividend_i;
      d_d    = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d   = {n_q[DataW-2:0], 1'b0};
      rem_d = trial[DataW] ? shifted[DataW-1:0] : trial[DataW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== verif/tb_msws_bounded_random.sv =====
`timescale 1ns / 1ps

module tb_msws_bounded_random;
  import msws_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned RandomItems = 1040;
  localparam int unsigned CalmFirst   = 200;
  localparam int unsigned CalmLast    = 400;
  localparam int unsigned TailCycles  = 300;

  // One response as the generator should deliver it.
  typedef struct packed {
    data_t value;
    logic  bound_error;
  } draw_t;

  // One row of the directed table; typed rows carry an expectation read off directly.
  typedef struct packed {
    data_t bound;
    logic  typed;
    draw_t draw;
  } bound_row_t;

  localparam int unsigned NumRows = 16;
  localparam bound_row_t BoundRows [NumRows] = '{
    '{64'h0,                  1'b1, '{64'h0, 1'b1}},
    '{64'h1,                  1'b1, '{64'h0, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{64'h0, 1'b0}},
    '{64'h2,                  1'b0, '{64'h0, 1'b0}},
    '{64'h3,                  1'b0, '{64'h0, 1'b0}},
    '{64'h8000_0000_0000_0000, 1'b0, '{64'h0, 1'b0}},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '{64'h0, 1'b0}},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, '{64'h0, 1'b0}},
    '{64'h0000_0001_0000_0000, 1'b0, '{64'h0, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '{64'h0, 1'b0}},
    '{64'h0,                  1'b1, '{64'h0, 1'b1}},
    '{64'h5555_5555_5555_5555, 1'b0, '{64'h0, 1'b0}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '{64'h0, 1'b0}},
    '{64'hA,                  1'b0, '{64'h0, 1'b0}},
    '{64'h1,                  1'b1, '{64'h0, 1'b0}},
    '{64'hDEAD_BEEF_0000_0001, 1'b0, '{64'h0, 1'b0}}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  data_t cfg_wdata_i;
  logic  calm;

  msws_req_if req_bus ();
  msws_rsp_if rsp_bus ();

  msws_bounded_random dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  always #6 clk_i = ~clk_i;

  // Generator model state and the seed register copy.
  data_t seed_reg;
  data_t gen_mixer;
  data_t gen_weyl;
  logic  gen_seeded;

  draw_t       pending_draws [$];
  int unsigned error_count;

  // Advance the generator once and reduce the new mixer by the bound.
  function automatic draw_t predict_draw(data_t bound);
    data_t sq;
    draw_t d;
    if (!gen_seeded) begin
      gen_mixer  = seed_reg;
      gen_seeded = 1'b1;
    end
    sq        = gen_mixer * gen_mixer;
    gen_weyl  = gen_weyl + WeylStep;
    sq        = sq + gen_weyl;
    gen_mixer = {sq[HalfW-1:0], sq[DataW-1:HalfW]};
    d.bound_error = (bound == '0);
    if (d.bound_error) begin
      d.value = '0;
    end else begin
      d.value = gen_mixer % bound;
    end
    return d;
  endfunction

  // Mix of bound shapes: zero, tiny, 32-bit, full width, shifted to random widths, powers of two, near the top.
  function automatic data_t pick_bound();
    data_t b;
    case ($urandom_range(0, 9))
      0: begin
        b = '0;
      end
      1, 2: begin
        b = data_t'($urandom_range(1, 20));
      end
      3: begin
        b = data_t'($urandom);
      end
      4: begin
        b = data_t'(1) << $urandom_range(0, DataW - 1);
      end
      5: begin
        b = '1 - data_t'($urandom_range(0, 15));
      end
      6: begin
        b = {$urandom, $urandom} >> $urandom_range(0, DataW - 1);
      end
      default: begin
        b = {$urandom, $urandom};
      end
    endcase
    return b;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  // Write the seed register for one clock, then drop the write enable again before returning.
  task automatic write_seed(input data_t v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    seed_reg = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one bound, with random idle cycles ahead of it outside the calm stretch, and record the expected draw.
  task automatic send_bound(input data_t b, input logic typed, input draw_t typed_draw);
    draw_t d;
    while (!calm && $urandom_range(0, 99) < 15) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.bound <= b;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    d = predict_draw(b);
    pending_draws.push_back(typed ? typed_draw : d);
  endtask

  // Hold the request side until every outstanding draw has returned.
  task automatic drain_draws();
    req_bus.valid <= 1'b0;
    while (pending_draws.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // Response side: random back-pressure except during the calm stretch.
  always @(posedge clk_i) begin
    rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // Compare every response transfer with the oldest expected draw.
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_draws.size() == 0) begin
        flag_error($sformatf("unexpected response value %h err %b",
                             rsp_bus.value, rsp_bus.bound_error));
      end else begin
        want = pending_draws.pop_front();
        if (rsp_bus.value !== want.value || rsp_bus.bound_error !== want.bound_error) begin
          flag_error($sformatf("mismatch: value exp %h got %h, err exp %b got %b",
                               want.value, rsp_bus.value, want.bound_error,
                               rsp_bus.bound_error));
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_msws_bounded_random: done, errors");
    $finish;
  end

  // Main stimulus sequence.
  initial begin : stimulus
    data_t loaded_seed;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req_bus.valid = 1'b0;
    req_bus.bound = '0;
    rsp_bus.ready = 1'b0;
    calm          = 1'b0;
    seed_reg      = '0;
    gen_mixer     = '0;
    gen_weyl      = '0;
    gen_seeded    = 1'b0;
    error_count   = 0;
    loaded_seed   = {$urandom, $urandom};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two writes before the first request: only the last one is loaded.
    write_seed('1);
    write_seed(loaded_seed);

    for (int i = 0; i < NumRows; i++) begin
      send_bound(BoundRows[i].bound, BoundRows[i].typed, BoundRows[i].draw);
    end
    drain_draws();

    // Seed changes after seeding must not reload the mixer.
    write_seed('0);

    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= CalmFirst && i < CalmLast);
      if (i == RandomItems / 2) begin
        drain_draws();
        write_seed('1);
      end
      send_bound(pick_bound(), 1'b0, '0);
    end
    calm = 1'b0;
    drain_draws();
    repeat (TailCycles) @(posedge clk_i);

    if (pending_draws.size() != 0) begin
      flag_error($sformatf("%0d expected draws never returned", pending_draws.size()));
    end
    if (error_count == 0) begin
      $display("tb_msws_bounded_random: done, clean");
    end else begin
      $display("tb_msws_bounded_random: done, errors");
    end
    $finish;
  end

endmodule
